### sv/pidaw_pkg.sv
// Package for the PID controller block: payload word types, request and
// register codes, fixed field widths and a small width helper.
// Depends on nothing; every other file imports it.
package pidaw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 24;
  localparam int POLE_W   = 17;
  localparam int ACC_W    = 40;
  localparam int SUM_W    = 42;
  localparam int IDX_W    = 3;
  localparam int REQ_W    = 2;

  localparam int ERR_W  = SAMPLE_W + 1;
  localparam int ESUM_W = SAMPLE_W + 2;
  localparam int P_W    = GAIN_W + ERR_W;
  localparam int I_W    = GAIN_W + ESUM_W;
  localparam int D_W    = GAIN_W + ERR_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_UPDATE  = 2'd0,
    REQ_CLR_INT = 2'd1,
    REQ_CLR_ALL = 2'd2
  } req_t;

  typedef enum logic [IDX_W-1:0] {
    REG_P_GAIN  = 3'd0,
    REG_I_GAIN  = 3'd1,
    REG_D_GAIN  = 3'd2,
    REG_D_POLE  = 3'd3,
    REG_OUT_MAX = 3'd4,
    REG_OUT_MIN = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [REQ_W-1:0]           req_type;
    logic signed [SAMPLE_W-1:0] setpoint;
    logic signed [SAMPLE_W-1:0] measurement;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] drive;
    logic                       limited;
  } res_t;

  // Step control handed to each stage: advance strobe and the request kind.
  typedef struct packed {
    logic             load;
    logic [REQ_W-1:0] req_type;
  } step_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### sv/pidaw_front.sv
// Front stage of the PID controller: error, error sum, measurement delta and
// the three gain products, registered. Holds prev_error and prev_measurement.
// Depends on pidaw_pkg.
module pidaw_front import pidaw_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  step_t                      step,
  input  logic signed [SAMPLE_W-1:0] setpoint,
  input  logic signed [SAMPLE_W-1:0] measurement,
  input  logic signed [GAIN_W-1:0]   p_gain,
  input  logic signed [GAIN_W-1:0]   i_gain,
  input  logic signed [GAIN_W-1:0]   d_gain,
  output logic signed [P_W-1:0]      p_term,
  output logic signed [I_W-1:0]      i_incr,
  output logic signed [D_W-1:0]      d_incr
);

  logic signed [ERR_W-1:0]    prev_error;
  logic signed [SAMPLE_W-1:0] prev_meas;

  logic signed [ERR_W-1:0]  err;
  logic signed [ESUM_W-1:0] err_sum;
  logic signed [ERR_W-1:0]  meas_delta;

  always_comb begin
    err        = ERR_W'(setpoint) - ERR_W'(measurement);
    err_sum    = ESUM_W'(err) + ESUM_W'(prev_error);
    meas_delta = ERR_W'(measurement) - ERR_W'(prev_meas);
  end

  always_ff @(posedge clk) begin
    if (step.load) begin
      p_term <= P_W'(p_gain) * P_W'(err);
      i_incr <= I_W'(i_gain) * I_W'(err_sum);
      d_incr <= D_W'(d_gain) * D_W'(meas_delta);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      prev_meas  <= '0;
    end else if (step.load) begin
      unique case (step.req_type)
        REQ_UPDATE: begin
          prev_error <= err;
          prev_meas  <= measurement;
        end
        REQ_CLR_ALL: begin
          prev_error <= '0;
          prev_meas  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### sv/pidaw_loop.sv
// Loop stage of the PID controller: integrator with dynamic clamp, filtered
// derivative, sum, overflow reset, rounding and output limit clamp.
// Depends on pidaw_pkg.
module pidaw_loop import pidaw_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  step_t                      step,
  input  logic signed [P_W-1:0]      p_term,
  input  logic signed [I_W-1:0]      i_incr,
  input  logic signed [D_W-1:0]      d_incr,
  input  logic signed [POLE_W-1:0]   d_pole,
  input  logic signed [SAMPLE_W-1:0] out_max,
  input  logic signed [SAMPLE_W-1:0] out_min,
  output logic signed [SAMPLE_W-1:0] drive,
  output logic                       limited
);

  localparam int DP_W = POLE_W + ACC_W;
  localparam int W = max_int(max_int(max_int(ACC_W, I_W), max_int(SAMPLE_W + FRAC_BITS, P_W)),
                             DP_W - FRAC_BITS) + 3;

  logic signed [ACC_W-1:0] integ;
  logic signed [ACC_W-1:0] deriv;

  logic signed [W-1:0]     p_w, i_raw, i_clamp, hi, lo, i_hi, i_lo;
  logic signed [ACC_W-1:0] i_val, d_val;
  logic signed [DP_W-1:0]  d_prod, d_shift;
  logic signed [W-1:0]     d_raw, sum, sum_eff, rounded, drv, lim_hi, lim_lo;
  logic                    ovf;
  logic signed [SAMPLE_W-1:0] drive_next;
  logic                    limited_next;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [W-1:0] v);
    logic [W-ACC_W:0] top;
    top = v[W-1:ACC_W-1];
    if ((&top) || !(|top)) begin
      return v[ACC_W-1:0];
    end
    return v[W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

  always_comb begin
    p_w   = W'(p_term);
    i_raw = W'(integ) + W'(i_incr);
    hi    = W'(out_max) <<< FRAC_BITS;
    lo    = W'(out_min) <<< FRAC_BITS;
    i_hi  = (hi > p_w) ? hi - p_w : W'(0);
    i_lo  = (lo < p_w) ? lo - p_w : W'(0);
    priority if (i_raw > i_hi) begin
      i_clamp = i_hi;
    end else if (i_raw < i_lo) begin
      i_clamp = i_lo;
    end else begin
      i_clamp = i_raw;
    end
    i_val = sat_acc(i_clamp);

    // The pole product is Q.2F; the shift floors it back to Q.F.
    d_prod  = DP_W'(d_pole) * DP_W'(deriv);
    d_shift = d_prod >>> FRAC_BITS;
    d_raw   = -(W'(d_incr) + W'(d_shift));
    d_val   = sat_acc(d_raw);

    sum     = p_w + W'(i_val) + W'(d_val);
    ovf     = !((&sum[W-1:SUM_W-1]) || !(|sum[W-1:SUM_W-1]));
    sum_eff = ovf ? W'(0) : sum;
    rounded = sum_eff + (W'(1) <<< (FRAC_BITS - 1));
    drv     = rounded >>> FRAC_BITS;

    lim_hi = W'(out_max);
    lim_lo = W'(out_min);
    priority if (drv > lim_hi) begin
      drive_next   = out_max;
      limited_next = 1'b1;
    end else if (drv < lim_lo) begin
      drive_next   = out_min;
      limited_next = 1'b1;
    end else begin
      drive_next   = drv[SAMPLE_W-1:0];
      limited_next = ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      deriv <= '0;
    end else if (step.load) begin
      unique case (step.req_type)
        REQ_UPDATE: begin
          integ <= ovf ? '0 : i_val;
          deriv <= ovf ? '0 : d_val;
        end
        REQ_CLR_INT: begin
          integ <= '0;
        end
        REQ_CLR_ALL: begin
          integ <= '0;
          deriv <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step.load && step.req_type == REQ_UPDATE) begin
      drive   <= drive_next;
      limited <= limited_next;
    end
  end

endmodule

### sv/pid_antiwindup_filtered_derivative.sv
// PID controller with trapezoidal integrator, anti-windup clamp and a
// band-limited derivative on the measurement.
//
// Channels: cmd carries one request word (update, clear integrator, clear
// all); res carries one drive word per update request only; cfg writes the
// gain and limit registers by index and is always ready. Configuration must
// be changed only while no request is in flight; the block does not enforce it.
// A word accepted on cmd is registered in the input register, its gain
// products in the front stage, and its result word in the loop stage, from which it stands on res.
// Throughput: one request word per cycle while res is not stalled; the
// integrator and derivative feedback closes combinationally within the loop
// stage, which with the d_pole by derivative multiply sets the clock period.
// Reset clears the loop state, the pipeline valid bits and the registers to
// their defaults (limits at full sample range, gains zero).
// When res is stalled, the result word holds; the stages behind it keep
// filling, and clear requests keep draining since they give no result, so
// cmd_ready drops only once the input register cannot move on.
// Depends on pidaw_pkg, pidaw_front and pidaw_loop.
module pid_antiwindup_filtered_derivative import pidaw_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [GAIN_W-1:0] cfg_data
);

  logic signed [GAIN_W-1:0]   p_gain, i_gain, d_gain;
  logic signed [POLE_W-1:0]   d_pole;
  logic signed [SAMPLE_W-1:0] out_max, out_min;

  cmd_t             s1;
  logic             s1_valid;
  logic             s2_valid;
  logic [REQ_W-1:0] s2_req;

  logic  cmd_fire, s1_adv, s2_adv, s2_update, res_free;
  step_t front_step, loop_step;

  logic signed [P_W-1:0]      p_term;
  logic signed [I_W-1:0]      i_incr;
  logic signed [D_W-1:0]      d_incr;
  logic signed [SAMPLE_W-1:0] drive;
  logic                       limited;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain  <= '0;
      i_gain  <= '0;
      d_gain  <= '0;
      d_pole  <= '0;
      out_max <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      out_min <= {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_P_GAIN:  p_gain  <= cfg_data;
        REG_I_GAIN:  i_gain  <= cfg_data;
        REG_D_GAIN:  d_gain  <= cfg_data;
        REG_D_POLE:  d_pole  <= cfg_data[POLE_W-1:0];
        REG_OUT_MAX: out_max <= cfg_data[SAMPLE_W-1:0];
        REG_OUT_MIN: out_min <= cfg_data[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Requests without a result leave the loop stage without waiting on res.
  always_comb begin
    res_free  = !res_valid || res_ready;
    s2_update = (s2_req == REQ_UPDATE);
    s2_adv    = s2_valid && (!s2_update || res_free);
    s1_adv    = s1_valid && (!s2_valid || s2_adv);
    cmd_ready = !s1_valid || s1_adv;
    cmd_fire  = cmd_valid && cmd_ready;
    front_step = '{load: s1_adv, req_type: s1.req_type};
    loop_step  = '{load: s2_adv, req_type: s2_req};
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1 <= cmd;
    end
    if (s1_adv) begin
      s2_req <= s1.req_type;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv && s2_update) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  pidaw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .step        (front_step),
    .setpoint    (s1.setpoint),
    .measurement (s1.measurement),
    .p_gain      (p_gain),
    .i_gain      (i_gain),
    .d_gain      (d_gain),
    .p_term      (p_term),
    .i_incr      (i_incr),
    .d_incr      (d_incr)
  );

  pidaw_loop #(
    .FRAC_BITS (FRAC_BITS)
  ) u_loop (
    .clk     (clk),
    .rst     (rst),
    .step    (loop_step),
    .p_term  (p_term),
    .i_incr  (i_incr),
    .d_incr  (d_incr),
    .d_pole  (d_pole),
    .out_max (out_max),
    .out_min (out_min),
    .drive   (drive),
    .limited (limited)
  );

  assign res = '{drive: drive, limited: limited};

  // The input register only blocks new words while it holds one.
  assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> s1_valid)
    else $error("cmd_ready low with an empty input register");

  // A new result word only comes from an update request leaving the loop stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s2_valid && s2_req == REQ_UPDATE))
    else $error("result word without an update request");

  // The drive never exceeds the upper limit unless the lower limit took over.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && ($signed(res.drive) > out_max) |-> res.drive == out_min)
    else $error("drive above out_max");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for pid_antiwindup_filtered_derivative: directed and random
// request words against a cycle-free predictor of the loop. Depends on pidaw_pkg and the RTL.
module testbench;
  import pidaw_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYC = 8;
  localparam int IDLE_LIMIT = 50000;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_WORDS = 200;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd_word = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  // Predicted controller settings and loop state.
  longint g_p = 0, g_i = 0, g_d = 0, g_pole = 0;
  longint lim_hi = 32767, lim_lo = -32768;
  longint loop_integ = 0, loop_deriv = 0, loop_prev_err = 0, loop_prev_meas = 0;

  cmd_t cmd_q[$];
  res_t drive_exp_q[$];
  int n_errors = 0;
  int n_results = 0;
  int track_sp = 0;

  // Sender and receiver idling controls.
  bit tx_gaps = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [3:0] rx_pos = '0;
  int long_hold_left = 0;
  bit long_hold_done = 1'b0;

  always #2 clk = ~clk;

  pid_antiwindup_filtered_derivative #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd_word),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  task automatic report(input string msg);
    if (n_errors < 100) begin
      $display("mismatch: %s", msg);
    end
    n_errors++;
  endtask

  function automatic longint clip_acc(input longint x);
    if (x > ACC_MAX) return ACC_MAX;
    if (x < -ACC_MAX - 1) return -ACC_MAX - 1;
    return x;
  endfunction

  function automatic void apply_setting(input logic [IDX_W-1:0] idx,
                                        input logic [GAIN_W-1:0] val);
    unique case (idx)
      REG_P_GAIN:  g_p = longint'($signed(val));
      REG_I_GAIN:  g_i = longint'($signed(val));
      REG_D_GAIN:  g_d = longint'($signed(val));
      REG_D_POLE:  g_pole = longint'($signed(val[POLE_W-1:0]));
      REG_OUT_MAX: lim_hi = longint'($signed(val[SAMPLE_W-1:0]));
      REG_OUT_MIN: lim_lo = longint'($signed(val[SAMPLE_W-1:0]));
      default: ;
    endcase
  endfunction

  // Advances the loop state by one request word and queues the drive word it yields.
  function automatic void pid_predict(input cmd_t c);
    longint sp, meas, err, p, hi, lo, imax, imin, ival, dval, sum, drv;
    logic lim;
    res_t r;
    lim = 1'b0;
    unique case (c.req_type)
      REQ_CLR_INT: loop_integ = 0;
      REQ_CLR_ALL: begin
        loop_integ = 0;
        loop_deriv = 0;
        loop_prev_err = 0;
        loop_prev_meas = 0;
      end
      REQ_UPDATE: begin
        sp = longint'($signed(c.setpoint));
        meas = longint'($signed(c.measurement));
        err = sp - meas;
        p = g_p * err;
        ival = loop_integ + g_i * (err + loop_prev_err);
        hi = lim_hi * (longint'(1) <<< FRAC);
        lo = lim_lo * (longint'(1) <<< FRAC);
        imax = (hi > p) ? hi - p : 0;
        imin = (lo < p) ? lo - p : 0;
        if (ival > imax) ival = imax;
        else if (ival < imin) ival = imin;
        ival = clip_acc(ival);
        dval = -(g_d * (meas - loop_prev_meas) + ((g_pole * loop_deriv) >>> FRAC));
        dval = clip_acc(dval);
        sum = p + ival + dval;
        if (sum > SUM_MAX || sum < -SUM_MAX - 1) begin
          ival = 0;
          dval = 0;
          sum = 0;
          lim = 1'b1;
        end
        loop_integ = ival;
        loop_deriv = dval;
        drv = (sum + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (drv > lim_hi) begin
          drv = lim_hi;
          lim = 1'b1;
        end else if (drv < lim_lo) begin
          drv = lim_lo;
          lim = 1'b1;
        end
        loop_prev_err = err;
        loop_prev_meas = meas;
        r.drive = drv[SAMPLE_W-1:0];
        r.limited = lim;
        drive_exp_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Sender: bursts of words separated by random gaps when gaps are enabled.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) pid_predict(cmd_word);
      if (!cmd_valid || cmd_ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          cmd_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cmd_word <= cmd_q.pop_front();
          cmd_valid <= 1'b1;
          if (tx_gaps) begin
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 12);
              gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(1, 3);
            end
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word and stalls on a rotating pattern, with one
  // long hold-off while the sender still has plenty of words to offer.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (drive_exp_q.size() == 0) begin
          report($sformatf("result word drive %0d with nothing expected",
                           $signed(res_word.drive)));
        end else begin
          want = drive_exp_q.pop_front();
          if (res_word.drive !== want.drive)
            report($sformatf("drive got %0d want %0d",
                             $signed(res_word.drive), $signed(want.drive)));
          if (res_word.limited !== want.limited)
            report($sformatf("limited got %0b want %0b",
                             res_word.limited, want.limited));
        end
        n_results++;
        if (!long_hold_done && n_results >= 250 && cmd_q.size() > 30) begin
          long_hold_left = 400;
          long_hold_done = 1'b1;
        end
      end
      if (long_hold_left > 0) begin
        long_hold_left = long_hold_left - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= rx_pattern[rx_pos];
        rx_pos = rx_pos + 1'b1;
      end
    end
  end

  // Holds valid high between writes; the caller lowers it after the last one.
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_setting(idx, val);
  endtask

  task automatic load_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                            input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] pole,
                            input logic [GAIN_W-1:0] omax, input logic [GAIN_W-1:0] omin);
    cfg_write(REG_P_GAIN, kp);
    cfg_write(REG_I_GAIN, ki);
    cfg_write(REG_D_GAIN, kd);
    cfg_write(REG_D_POLE, pole);
    cfg_write(REG_OUT_MAX, omax);
    cfg_write(REG_OUT_MIN, omin);
    cfg_valid <= 1'b0;
  endtask

  function automatic void queue_word(input logic [REQ_W-1:0] req, input int sp, input int ms);
    cmd_t c;
    c.req_type = req;
    c.setpoint = sp[SAMPLE_W-1:0];
    c.measurement = ms[SAMPLE_W-1:0];
    cmd_q.push_back(c);
  endfunction

  // Mostly a measurement tracking a slowly stepping setpoint, the rest raw noise.
  function automatic void queue_random_word();
    int pick, ms;
    logic [REQ_W-1:0] req;
    pick = $urandom_range(0, 99);
    req = REQ_UPDATE;
    if (pick < 5) req = REQ_CLR_INT;
    else if (pick < 8) req = REQ_CLR_ALL;
    else if (pick < 10) req = REQ_UNUSED;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 15) == 0) track_sp = int'($urandom_range(0, 65535)) - 32768;
      ms = track_sp + int'($urandom_range(0, 400)) - 200;
      if (ms > 32767) ms = 32767;
      if (ms < -32768) ms = -32768;
      queue_word(req, track_sp, ms);
    end else begin
      queue_word(req, int'($urandom()), int'($urandom()));
    end
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain(input int span);
    if (span == 0) return GAIN_W'($urandom());
    return GAIN_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic wait_idle();
    int waited;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while ((cmd_q.size() != 0 || cmd_valid || drive_exp_q.size() != 0)
               && waited < IDLE_LIMIT);
    if (drive_exp_q.size() != 0)
      report($sformatf("%0d expected words never arrived", drive_exp_q.size()));
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  initial begin
    int span, la, lb, omax, omin, kind;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Moderate gains; writes to unassigned indexes must leave everything alone.
    tx_gaps = 1'b1;
    rx_pattern = 16'hB6D5;
    cfg_write(REG_SPARE_A, 24'h123456);
    cfg_write(REG_SPARE_B, 24'hFFFFFF);
    load_gains(24'h010000, 24'h004000, 24'h008000, 24'h008000,
               GAIN_W'(1000), GAIN_W'(-1000));
    queue_word(REQ_UPDATE, 32767, -32768);
    queue_word(REQ_UPDATE, -32768, 32767);
    queue_word(REQ_UPDATE, 0, 0);
    queue_word(REQ_UNUSED, 123, -45);
    queue_word(REQ_UPDATE, 500, 400);
    queue_word(REQ_CLR_INT, 7, 7);
    queue_word(REQ_UPDATE, 500, 400);
    queue_word(REQ_CLR_ALL, -1, 1);
    queue_word(REQ_UPDATE, 0, 0);
    queue_word(REQ_UPDATE, -700, 100);
    wait_idle();

    // Extreme gains with a pole of minus one: the measurement swings rail to rail
    // so both accumulators run into saturation.
    load_gains(GAIN_W'(-8388608), GAIN_W'(8388607), GAIN_W'(8388607), 24'h010000,
               GAIN_W'(32767), GAIN_W'(-32768));
    for (int k = 0; k < 6; k++) begin
      if (k % 2 == 0) queue_word(REQ_UPDATE, -32768, 32767);
      else queue_word(REQ_UPDATE, 32767, -32768);
    end
    wait_idle();

    // Crossed limits: the upper limit is checked first and wins where both apply.
    load_gains(GAIN_W'(8388607), GAIN_W'(-8388608), GAIN_W'(-8388608), 24'h00FFFF,
               GAIN_W'(-100), GAIN_W'(100));
    queue_word(REQ_UPDATE, 0, 0);
    queue_word(REQ_UPDATE, 32767, -32768);
    queue_word(REQ_UPDATE, -32768, 32767);
    queue_word(REQ_UPDATE, 5, 5);
    queue_word(REQ_CLR_ALL, 0, 0);
    queue_word(REQ_UPDATE, 1, 0);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: span = 1 << 12;
        1: span = 1 << 16;
        2: span = 1 << 18;
        default: span = 0;
      endcase
      la = int'($urandom_range(0, 65535)) - 32768;
      lb = int'($urandom_range(0, 65535)) - 32768;
      kind = $urandom_range(0, 5);
      if (kind == 0) begin
        omax = 32767;
        omin = -32768;
      end else if (kind == 1) begin
        omax = (la < lb) ? la : lb;
        omin = (la < lb) ? lb : la;
      end else begin
        omax = (la < lb) ? lb : la;
        omin = (la < lb) ? la : lb;
      end
      load_gains(rand_gain(span), rand_gain(span), rand_gain(span), GAIN_W'($urandom()),
                 GAIN_W'(omax), GAIN_W'(omin));
      if (ph == 0) begin
        tx_gaps = 1'b0;
        rx_pattern = 16'hFFFF;
      end else begin
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                 : (16'($urandom()) | 16'h0101);
      end
      for (int k = 0; k < PHASE_WORDS; k++) queue_random_word();
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
